/* src/kuf_pkg.sv */
package kuf_pkg;

  localparam int KUF_MAX_VERTICES = 4096;

  localparam int ID_W       = 12;
  localparam int VC_W       = 13;
  localparam int QUOTA_W    = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam int VERDICT_W  = 3;

  localparam logic [VC_W-1:0] VC_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT  = 1'b0,
    REG_NONTREE_QUOTA = 1'b1
  } cfg_reg_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_TREE    = 3'd0,
    VERDICT_NONTREE = 3'd1,
    VERDICT_DISCARD = 3'd2,
    VERDICT_IGNORED = 3'd3,
    VERDICT_INVALID = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_WALK,
    ST_COMP,
    ST_LINK,
    ST_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic sel_b;
    logic rd_start;
    logic walk;
    logic latch_root;
    logic comp;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic early;
    logic root_found;
    logic start_is_root;
    logic comp_last;
  } dp_stat_t;

endpackage

/* src/kuf_ctrl.sv */
module kuf_ctrl
  import kuf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    cmd.sel_b = side_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          side_nxt    = 1'b0;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.early) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_RESULT;
        end else begin
          cmd.rd_start = 1'b1;
          state_nxt    = ST_WALK;
        end
      end
      ST_START: begin
        cmd.rd_start = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        if (stat.root_found) begin
          cmd.latch_root = 1'b1;
          if (stat.start_is_root) begin
            if (side_r) begin
              state_nxt = ST_LINK;
            end else begin
              side_nxt  = 1'b1;
              state_nxt = ST_START;
            end
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = ST_COMP;
          end
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_COMP: begin
        cmd.comp = 1'b1;
        if (stat.comp_last) begin
          if (side_r) begin
            state_nxt = ST_LINK;
          end else begin
            side_nxt  = 1'b1;
            state_nxt = ST_START;
          end
        end
      end
      ST_LINK: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESULT);

endmodule

/* src/kuf_dpath.sv */
module kuf_dpath
  import kuf_pkg::*;
#(
  parameter int MAX_VERTICES = KUF_MAX_VERTICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [ID_W-1:0]       in_first_vertex,
  input  logic [ID_W-1:0]       in_second_vertex,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [VERDICT_W-1:0]  out_verdict,
  output logic [ID_W-1:0]       out_edge_from,
  output logic [ID_W-1:0]       out_edge_to,
  output logic                  out_tree_done
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (NW > VC_W) ? NW : VC_W;

  // parent table
  logic [AW-1:0] mem [MAX_VERTICES];
  logic [AW-1:0] rd_q;

  logic [VC_W-1:0]    vc_r;
  logic [QUOTA_W-1:0] quota_r;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      clr_r;
  logic [ID_W-1:0]    a_r, b_r;
  logic [AW-1:0]      cur_r, root_r, ra_r;

  logic [AW-1:0]      a_addr, b_addr, start_addr;
  logic [CMP_W-1:0]   n_eff, n_m1;
  logic               ignored, invalid, early, differ;
  logic               link_en, nontree_en;
  verdict_t           verdict;
  logic               done_nxt;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, wr_data, rd_addr;

  assign a_addr     = AW'(a_r);
  assign b_addr     = AW'(b_r);
  assign start_addr = cmd.sel_b ? b_addr : a_addr;

  // vertex count: zero counts as one, saturate at table depth
  always_comb begin
    if (vc_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(vc_r) > CMP_W'(MAX_VERTICES)) begin
      n_eff = CMP_W'(MAX_VERTICES);
    end else begin
      n_eff = CMP_W'(vc_r);
    end
  end

  assign n_m1    = n_eff - CMP_W'(1);
  assign ignored = (CMP_W'(cnt_r) >= n_m1);
  assign invalid = (CMP_W'(a_r) >= n_eff) || (CMP_W'(b_r) >= n_eff);
  assign early   = ignored || invalid;
  assign differ  = (ra_r != root_r);

  assign link_en    = cmd.finish && !early && differ;
  assign nontree_en = cmd.finish && !early && !differ && (quota_r != '0);
  assign cnt_nxt    = cnt_r + AW'(link_en);
  assign done_nxt   = (CMP_W'(cnt_nxt) >= n_m1);

  always_comb begin
    priority if (ignored) verdict = VERDICT_IGNORED;
    else if (invalid)     verdict = VERDICT_INVALID;
    else if (differ)      verdict = VERDICT_TREE;
    else if (quota_r != '0) verdict = VERDICT_NONTREE;
    else                  verdict = VERDICT_DISCARD;
  end

  // one write port: clearing pass, path compression or link
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_r;
    wr_data = clr_r;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.comp) begin
      wr_en   = 1'b1;
      wr_addr = cur_r;
      wr_data = root_r;
    end else if (link_en) begin
      wr_en   = 1'b1;
      wr_addr = root_r;
      wr_data = ra_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = cmd.rd_start || cmd.walk || cmd.comp;
  assign rd_addr = cmd.rd_start ? start_addr : rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign stat.clr_last      = (clr_r == AW'(MAX_VERTICES - 1));
  assign stat.early         = early;
  assign stat.root_found    = (rd_q == cur_r);
  assign stat.start_is_root = (start_addr == cur_r);
  assign stat.comp_last     = (rd_q == root_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r    <= VC_RESET;
      quota_r <= '0;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_VERTEX_COUNT:  vc_r    <= cfg_data[VC_W-1:0];
          REG_NONTREE_QUOTA: quota_r <= cfg_data[QUOTA_W-1:0];
        endcase
      end else if (nontree_en) begin
        quota_r <= quota_r - QUOTA_W'(1);
      end
      cnt_r <= cnt_nxt;
      if (cmd.clr_wr && !stat.clr_last) clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_r <= in_first_vertex;
      b_r <= in_second_vertex;
    end
    if (cmd.rd_start) begin
      cur_r <= start_addr;
    end else if (cmd.walk || cmd.comp) begin
      cur_r <= rd_q;
    end
    if (cmd.latch_root) begin
      root_r <= cur_r;
      if (!cmd.sel_b) ra_r <= cur_r;
    end
    if (cmd.finish) begin
      out_verdict   <= verdict;
      out_edge_from <= a_r;
      out_edge_to   <= b_r;
      out_tree_done <= done_nxt;
    end
  end

endmodule

/* src/kruskal_union_find_edge_select_unit.sv */
// kruskal edge acceptance with a union-find parent table
//
// items: pulse start while busy is low to hand in one edge (first/second
// vertex); the edge is taken at that clock edge. exactly one result per item
// comes back later on out_* with out_valid high for a single cycle; there is
// no backpressure, the receiver must take it in that cycle.
// config: cfg_valid/cfg_ready write channel, cfg_ready is always high;
// index 0 is vertex_count, index 1 is nontree_quota (also reloads the quota
// left). write config only while idle.
// flow: ignored or invalid edges go from the check state straight to the
// result state. otherwise each endpoint is walked to its root and, unless it
// is its own root, its path is compressed; then differing roots are linked;
// every hop costs one read of the parent ram on the walk and one read-plus-write
// on the path compression pass. a new edge is taken only once busy is low again.
// reset: synchronous, active low. after reset a clearing pass writes every
// parent entry to its own index, with busy high; config writes are still
// taken during that pass.
module kruskal_union_find_edge_select_unit
  import kuf_pkg::*;
#(
  parameter int MAX_VERTICES = KUF_MAX_VERTICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // edge input
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_W-1:0]       in_first_vertex,
  input  logic [ID_W-1:0]       in_second_vertex,
  // result
  output logic                  out_valid,
  output logic [VERDICT_W-1:0]  out_verdict,
  output logic [ID_W-1:0]       out_edge_from,
  output logic [ID_W-1:0]       out_edge_to,
  output logic                  out_tree_done,
  // config write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: clear pass, root walks, compression, link
  kuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // parent ram, counters, config registers, result registers
  kuf_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_first_vertex  (in_first_vertex),
    .in_second_vertex (in_second_vertex),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_verdict      (out_verdict),
    .out_edge_from    (out_edge_from),
    .out_edge_to      (out_edge_to),
    .out_tree_done    (out_tree_done)
  );

  // an accepted item keeps the block busy and never answers in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not hold the block busy");

  // a result only appears while the item is still owned by the block
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // one strobe per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an ignored edge always comes with the tree already complete
  a_tree_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_IGNORED) |-> out_tree_done)
    else $error("ignored edge without a complete tree");

endmodule
